// ===== rtl/md5bc_pkg.sv =====
package md5bc_pkg;

   typedef logic [31:0] word_type;

   localparam int WORDS_PER_BLOCK = 16;
   localparam int STEPS_PER_BLOCK = 64;

   // Sine-derived additive constants, one per step.
   localparam word_type K_TABLE [STEPS_PER_BLOCK] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotation amounts, indexed by {round, step[1:0]}.
   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word schedule of the four rounds.
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] s;
      logic [3:0] idx;
      s = step[3:0];
      case (step[5:4])
         2'd0:    idx = s;
         2'd1:    idx = (s * 4'd5) + 4'd1;
         2'd2:    idx = (s * 4'd3) + 4'd5;
         default: idx = s * 4'd7;
      endcase
      return idx;
   endfunction

   // Left rotation; the amount is never zero in this algorithm.
   function automatic word_type rotl(input word_type v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

endpackage

// ===== rtl/md5_block_compression.sv =====
// Channel   Direction  Handshake              Content
// req       in         req_tvalid/req_tready  message word, last_block on tlast
// rsp       out        rsp_tvalid/rsp_tready  digest word, word index on tuser
// csr       in         csr_we                 initial chaining words a..d
//
// Words are taken one per cycle; after the 16th word of a block the input
// stalls for a buffer read ahead, 64 rounds at one per cycle through the
// single buffer read port, and a fold into the chain.
// After a final block, four digest words follow; input waits until the last
// one is taken. Reset is synchronous and returns to waiting for a new message.
module md5_block_compression (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] message_word
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] S_COLLECT  = 3'd0;
   localparam logic [2:0] S_PREFETCH = 3'd1;
   localparam logic [2:0] S_ROUND    = 3'd2;
   localparam logic [2:0] S_FOLD     = 3'd3;
   localparam logic [2:0] S_EMIT     = 3'd4;

   localparam logic [1:0] REG_INIT_A = 2'd0;
   localparam logic [1:0] REG_INIT_B = 2'd1;
   localparam logic [1:0] REG_INIT_C = 2'd2;
   localparam logic [1:0] REG_INIT_D = 2'd3;

   logic [2:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic [3:0] count_ff, count_in;
   logic       mid_ff, mid_in;
   logic       last_ff, last_in;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   md5bc_pkg::word_type init_ff [4];
   md5bc_pkg::word_type chain_ff [4];
   md5bc_pkg::word_type chain_in [4];
   md5bc_pkg::word_type a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   md5bc_pkg::word_type ak_ff, ak_in;

   logic                req_xfer;
   logic                rsp_xfer;
   logic [3:0]          rd_addr;
   md5bc_pkg::word_type rd_word;
   md5bc_pkg::word_type b_new;
   logic [5:0]          step_next;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_valid_ff && rsp_tready;
   assign step_next = step_ff + 6'd1;

   // Block buffer: written in word order, read by the round schedule.
   md5bc_ram #(
      .WIDTH (32),
      .DEPTH (md5bc_pkg::WORDS_PER_BLOCK)
   ) u_buffer (
      .clock (clock),
      .we    (req_xfer),
      .waddr (count_ff),
      .wdata (req_tdata),
      .raddr (rd_addr),
      .rdata (rd_word)
   );

   // Read one step ahead so the word lands with its round.
   always_comb begin
      case (state_ff)
         S_PREFETCH: rd_addr = md5bc_pkg::msg_index(6'd0);
         S_ROUND:    rd_addr = md5bc_pkg::msg_index(step_next);
         default:    rd_addr = 4'd0;
      endcase
   end

   md5bc_round u_round (
      .step  (step_ff),
      .b     (b_ff),
      .c     (c_ff),
      .d     (d_ff),
      .ak    (ak_ff),
      .m     (rd_word),
      .b_new (b_new)
   );

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      mid_in       = mid_ff;
      last_in      = last_ff;
      out_cnt_in   = out_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      chain_in     = chain_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      ak_in        = ak_ff;
      case (state_ff)
         S_COLLECT: begin
            if (req_xfer) begin
               if (!mid_ff) begin
                  chain_in = init_ff;
                  mid_in   = 1'b1;
               end
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd15) begin
                  last_in  = req_tlast;
                  state_in = S_PREFETCH;
               end
            end
         end
         S_PREFETCH: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            ak_in    = chain_ff[0] + md5bc_pkg::K_TABLE[0];
            step_in  = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            a_in    = d_ff;
            b_in    = b_new;
            c_in    = b_ff;
            d_in    = c_ff;
            ak_in   = d_ff + md5bc_pkg::K_TABLE[step_next];
            step_in = step_next;
            if (step_ff == 6'd63) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (last_ff) begin
               mid_in       = 1'b0;
               out_cnt_in   = 2'd0;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               state_in = S_COLLECT;
            end
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               out_cnt_in = out_cnt_ff + 2'd1;
               if (out_cnt_ff == 2'd3) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_COLLECT;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         step_ff      <= 6'd0;
         count_ff     <= 4'd0;
         mid_ff       <= 1'b0;
         last_ff      <= 1'b0;
         out_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         mid_ff       <= mid_in;
         last_ff      <= last_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and chaining words.
   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      ak_ff    <= ak_in;
   end

   // Initial chaining value registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff[0] <= 32'h67452301;
         init_ff[1] <= 32'hefcdab89;
         init_ff[2] <= 32'h98badcfe;
         init_ff[3] <= 32'h10325476;
      end else if (csr_we) begin
         case (csr_addr)
            REG_INIT_A: init_ff[0] <= csr_wdata;
            REG_INIT_B: init_ff[1] <= csr_wdata;
            REG_INIT_C: init_ff[2] <= csr_wdata;
            REG_INIT_D: init_ff[3] <= csr_wdata;
            default:    init_ff[0] <= init_ff[0];
         endcase
      end
   end

   assign req_tready = (state_ff == S_COLLECT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = chain_ff[out_cnt_ff];
   assign rsp_tuser  = out_cnt_ff;
   assign rsp_tlast  = (out_cnt_ff == 2'd3);

   // Input and output never run at the same time.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest output pending");

   // The 64th round always hands over to the fold.
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && step_ff == 6'd63) |=> (state_ff == S_FOLD))
      else $error("round sequence did not end in fold");

   // A non-final block returns straight to collecting words.
   a_mid_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD && !last_ff) |=> (req_tready && !rsp_tvalid && mid_ff))
      else $error("non-final block did not resume collecting");

   // Output starts at word a after a final fold.
   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD && last_ff) |=> (rsp_tvalid && rsp_tuser == 2'd0 && !mid_ff))
      else $error("digest output did not start at word a");

endmodule

// ===== rtl/md5bc_ram.sv =====
module md5bc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/md5bc_round.sv =====
module md5bc_round (
   input  logic [5:0]          step,
   input  md5bc_pkg::word_type b,
   input  md5bc_pkg::word_type c,
   input  md5bc_pkg::word_type d,
   input  md5bc_pkg::word_type ak,
   input  md5bc_pkg::word_type m,
   output md5bc_pkg::word_type b_new
);

   md5bc_pkg::word_type mix;
   md5bc_pkg::word_type sum;

   // Round function selected by the upper step bits.
   always_comb begin
      case (step[5:4])
         2'd0:    mix = (b & c) | (~b & d);
         2'd1:    mix = (b & d) | (c & ~d);
         2'd2:    mix = b ^ c ^ d;
         default: mix = c ^ (b | ~d);
      endcase
   end

   // The a + K term arrives precomputed from the previous cycle.
   assign sum   = ak + mix + m;
   assign b_new = b + md5bc_pkg::rotl(sum, md5bc_pkg::ROT_TABLE[{step[5:4], step[1:0]}]);

endmodule
